@@ hdl/indexed_min_heap_decrease_key_defines.svh @@
// Assertion macros for the indexed min-heap block.
// Used by the top level only; no other dependencies.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
// implication checked every clock edge outside reset
`define IMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imh check failed");
// next-cycle implication
`define IMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imh check failed");
`endif

@@ hdl/imh_pkg.sv @@
// Shared constants and types for the indexed min-heap block.
// No dependencies.
package imh_pkg;
    localparam int MAX_NODES  = 256;
    localparam int DIST_WIDTH = 32;
    localparam int NODE_W     = 8;
    localparam int IN_DIST_W  = 32;
    localparam int CNT_W      = 9;

    typedef enum logic [1:0] {
        FUNC_INIT    = 2'd0,
        FUNC_EXTRACT = 2'd1,
        FUNC_DECKEY  = 2'd2,
        FUNC_MEMBER  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [NODE_W-1:0]    node_id;
        logic [IN_DIST_W-1:0] req_dist;
    } in_beat_t;

    typedef struct packed {
        logic [NODE_W-1:0]    out_node;
        logic [IN_DIST_W-1:0] out_distance;
        logic                 heap_was_empty;
        logic                 is_member;
        logic                 key_updated;
    } out_beat_t;
endpackage

@@ hdl/imh_if.sv @@
// Valid/ready channel interfaces for the indexed min-heap block.
// Depends on imh_pkg.
interface imh_in_if;
    logic              valid;
    logic              ready;
    imh_pkg::in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imh_out_if;
    logic               valid;
    logic               ready;
    imh_pkg::out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imh_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [imh_pkg::CNT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/indexed_min_heap_decrease_key.sv @@
// Indexed min-heap (Dijkstra priority queue) on two memories with registered
// reads and a single read port each. One beat at a time; the next beat is taken
// in the cycle after the result is loaded into the output register. Reset clears
// the heap count and result valid and sets the node count to 256; the memories
// are not cleared.
`include "indexed_min_heap_decrease_key_defines.svh"
module indexed_min_heap_decrease_key #(
    parameter int MAX_NODES  = imh_pkg::MAX_NODES,
    parameter int DIST_WIDTH = imh_pkg::DIST_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    imh_in_if.sink    in_ch,
    imh_out_if.source out_ch,
    imh_cfg_if.sink   cfg
);
    localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int PW  = $clog2(MAX_NODES + 1);
    localparam int NW  = imh_pkg::NODE_W;
    localparam int IDW = imh_pkg::IN_DIST_W;
    localparam int CW  = imh_pkg::CNT_W;
    localparam logic [DIST_WIDTH-1:0] DMAX = '1;
    localparam logic [PW-1:0] PMAX = PW'(MAX_NODES);

    typedef struct packed {
        logic [NW-1:0]         node;
        logic [DIST_WIDTH-1:0] cost;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_MEM_RD, S_MEM_CHK, S_DK_CHK,
        S_EX_RD, S_EX_SWAP, S_SD_RD, S_SD_RD2, S_SD_CHK, S_SU_RD, S_SU_CHK, S_DONE
    } state_t;

    // storage
    entry_t        heap_mem [MAX_NODES];
    logic [PW-1:0] pos_mem  [MAX_NODES];

    state_t              state_reg, state_next;
    logic [CW-1:0]       node_count_reg;
    logic [PW-1:0]       count_reg, count_next;
    logic [PW-1:0]       slot_reg, slot_next;
    logic [PW-1:0]       idx_reg, idx_next;
    entry_t              cur_reg, cur_next;
    entry_t              lch_reg, lch_next;
    imh_pkg::in_beat_t   beat_reg, beat_next;
    imh_pkg::out_beat_t  res_reg, res_next;
    imh_pkg::out_beat_t  out_reg, out_next;
    logic                res_valid_reg, res_valid_next;

    // memory ports
    logic          h_we, p_we;
    logic [AW-1:0] h_wa, p_wa, h_ra, p_ra;
    entry_t        h_wd, h_rd_reg;
    logic [PW-1:0] p_wd, p_rd_reg;

    // one write and one registered read per memory per cycle
    always_ff @(posedge clk)
    begin
        if (h_we)
            heap_mem[h_wa] <= h_wd;
        if (p_we)
            pos_mem[p_wa] <= p_wd;
        h_rd_reg <= heap_mem[h_ra];
        p_rd_reg <= pos_mem[p_ra];
    end

    logic [PW-1:0] ncap;
    logic [IDW-1:0] nd_in;
    logic [DIST_WIDTH-1:0] nd_sat;
    logic [PW:0] lidx, ridx;
    logic [PW-1:0] parent;
    logic in_fire;

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign in_fire       = in_ch.valid && in_ch.ready;
    assign cfg.ready     = 1'b1;
    assign out_ch.valid  = res_valid_reg;
    assign out_ch.data   = out_reg;

    always_comb
    begin
        ncap  = (node_count_reg > CW'(MAX_NODES)) ? PMAX : PW'(node_count_reg);
        nd_in = beat_reg.req_dist;
        if (IDW > DIST_WIDTH && (nd_in >> DIST_WIDTH) != '0)
            nd_sat = DMAX;
        else
            nd_sat = DIST_WIDTH'(nd_in);
        lidx   = {slot_reg, 1'b1};
        ridx   = {slot_reg, 1'b0} + (PW+1)'(2);
        parent = (slot_reg - PW'(1)) >> 1;
    end

    // sequencer: read, compare, write back
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        lch_next       = lch_reg;
        beat_next      = beat_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        res_valid_next = res_valid_reg;
        h_we = 1'b0; h_wa = '0; h_wd = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0;
        h_ra = '0; p_ra = '0;
        if (res_valid_reg && out_ch.ready)
            res_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    beat_next = in_ch.data;
                    res_next  = '0;
                    idx_next  = '0;
                    case (in_ch.data.func)
                        imh_pkg::FUNC_INIT:    state_next = S_INIT;
                        imh_pkg::FUNC_EXTRACT: state_next = S_EX_RD;
                        imh_pkg::FUNC_DECKEY:  state_next = S_MEM_RD;
                        default:               state_next = S_MEM_RD;
                    endcase
                end
            end
            S_INIT:
            begin
                // one node per cycle
                p_we = 1'b1;
                p_wa = AW'(idx_reg);
                p_wd = (idx_reg < ncap) ? idx_reg : PMAX;
                h_we = idx_reg < ncap;
                h_wa = AW'(idx_reg);
                h_wd = '{node: NW'(idx_reg), cost: DMAX};
                idx_next = idx_reg + PW'(1);
                if (idx_reg == PW'(MAX_NODES - 1))
                begin
                    count_next = ncap;
                    state_next = S_DONE;
                end
            end
            S_MEM_RD:
            begin
                p_ra = AW'(beat_reg.node_id);
                state_next = S_MEM_CHK;
            end
            S_MEM_CHK:
            begin
                if (32'(beat_reg.node_id) >= MAX_NODES || p_rd_reg >= count_reg)
                    state_next = S_DONE;
                else if (beat_reg.func == imh_pkg::FUNC_MEMBER)
                begin
                    res_next.is_member = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    slot_next  = p_rd_reg;
                    h_ra       = AW'(p_rd_reg);
                    state_next = S_DK_CHK;
                end
                if (beat_reg.func == imh_pkg::FUNC_MEMBER)
                    state_next = S_DONE;
            end
            S_DK_CHK:
            begin
                if (nd_sat < h_rd_reg.cost)
                begin
                    res_next.key_updated = 1'b1;
                    cur_next = '{node: h_rd_reg.node, cost: nd_sat};
                    state_next = S_SU_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_SU_RD:
            begin
                if (slot_reg == '0)
                begin
                    h_we = 1'b1; h_wa = '0; h_wd = cur_reg;
                    p_we = 1'b1; p_wa = AW'(cur_reg.node); p_wd = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    h_ra = AW'(parent);
                    state_next = S_SU_CHK;
                end
            end
            S_SU_CHK:
            begin
                // cur sits logically at slot; parent moves down if larger
                h_we = 1'b1; h_wa = AW'(slot_reg);
                p_we = 1'b1;
                if (cur_reg.cost < h_rd_reg.cost)
                begin
                    h_wd = h_rd_reg;
                    p_wa = AW'(h_rd_reg.node); p_wd = slot_reg;
                    slot_next = parent;
                    state_next = S_SU_RD;
                end
                else
                begin
                    h_wd = cur_reg;
                    p_wa = AW'(cur_reg.node); p_wd = slot_reg;
                    state_next = S_DONE;
                end
            end
            S_EX_RD:
            begin
                if (count_reg == '0)
                begin
                    res_next.out_distance = IDW'(DMAX);
                    res_next.heap_was_empty = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    h_ra = '0;
                    state_next = S_EX_SWAP;
                end
            end
            S_EX_SWAP:
            begin
                if (idx_reg == '0)
                begin
                    res_next.out_node     = h_rd_reg.node;
                    res_next.out_distance = IDW'(h_rd_reg.cost);
                    cur_next = h_rd_reg;
                    h_ra = AW'(count_reg - PW'(1));
                    idx_next = PW'(1);
                end
                else
                begin
                    // root goes to last slot, last entry sifts down from root
                    count_next = count_reg - PW'(1);
                    h_we = 1'b1; h_wa = AW'(count_reg - PW'(1)); h_wd = cur_reg;
                    p_we = 1'b1; p_wa = AW'(cur_reg.node); p_wd = count_reg - PW'(1);
                    cur_next  = h_rd_reg;
                    slot_next = '0;
                    state_next = (count_reg == PW'(1)) ? S_DONE : S_SD_RD;
                end
            end
            S_SD_RD:
            begin
                if (lidx >= (PW+1)'(count_reg))
                begin
                    h_we = 1'b1; h_wa = AW'(slot_reg); h_wd = cur_reg;
                    p_we = 1'b1; p_wa = AW'(cur_reg.node); p_wd = slot_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    h_ra = AW'(lidx);
                    state_next = S_SD_RD2;
                end
            end
            S_SD_RD2:
            begin
                lch_next = h_rd_reg;
                h_ra = AW'(ridx);
                state_next = S_SD_CHK;
            end
            S_SD_CHK:
            begin
                // pick the smaller child, left on a tie; stop if parent no larger
                h_we = 1'b1; h_wa = AW'(slot_reg);
                p_we = 1'b1;
                if (ridx < (PW+1)'(count_reg) && h_rd_reg.cost < lch_reg.cost
                    && h_rd_reg.cost < cur_reg.cost)
                begin
                    h_wd = h_rd_reg;
                    p_wa = AW'(h_rd_reg.node); p_wd = slot_reg;
                    slot_next = PW'(ridx);
                    state_next = S_SD_RD;
                end
                else if (lch_reg.cost < cur_reg.cost)
                begin
                    h_wd = lch_reg;
                    p_wa = AW'(lch_reg.node); p_wd = slot_reg;
                    slot_next = PW'(lidx);
                    state_next = S_SD_RD;
                end
                else
                begin
                    h_wd = cur_reg;
                    p_wa = AW'(cur_reg.node); p_wd = slot_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // load the output register once it is free
                if (!res_valid_reg || out_ch.ready)
                begin
                    out_next       = res_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state, node count, heap count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CW'(256);
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
                node_count_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        lch_reg  <= lch_next;
        beat_reg <= beat_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    `IMH_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= PMAX)
    `IMH_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `IMH_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, out_ch.valid)
endmodule

@@ sim/tb.sv @@
// Self-checking bench for the indexed min-heap block: drives op beats,
// predicts each result with a behavioral heap, and checks every result beat.
// Depends on imh_pkg, imh_if and the indexed_min_heap_decrease_key RTL.
`timescale 1ns / 100ps
module tb;
    logic clk;
    logic rst_n;
    imh_in_if  in_ch ();
    imh_out_if out_ch ();
    imh_cfg_if cfg ();

    indexed_min_heap_decrease_key dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    localparam logic [31:0] DIST_TOP = 32'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 4_000_000;

    // predictor state
    logic [8:0]  pq_limit;
    logic [8:0]  pq_count;
    logic [7:0]  pq_node [imh_pkg::MAX_NODES];
    logic [31:0] pq_dist [imh_pkg::MAX_NODES];
    logic [8:0]  pq_slot [imh_pkg::MAX_NODES];
    bit          pq_ready_init;

    imh_pkg::out_beat_t pending_results [$];
    int        error_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void swap_slots(input int a, input int b);
        logic [7:0]  na;
        logic [31:0] da;
        na = pq_node[a];
        da = pq_dist[a];
        pq_node[a] = pq_node[b];
        pq_dist[a] = pq_dist[b];
        pq_node[b] = na;
        pq_dist[b] = da;
        pq_slot[pq_node[a]] = 9'(a);
        pq_slot[pq_node[b]] = 9'(b);
    endfunction

    // apply one op to the heap and return the result beat it produces
    function automatic imh_pkg::out_beat_t heap_apply(imh_pkg::in_beat_t op);
        imh_pkg::out_beat_t res;
        int s, best, l, r, p, n;
        res = '0;
        case (imh_pkg::func_t'(op.func))
            imh_pkg::FUNC_INIT:
            begin
                n = (pq_limit > imh_pkg::MAX_NODES) ? imh_pkg::MAX_NODES : int'(pq_limit);
                for (int i = 0; i < imh_pkg::MAX_NODES; i++)
                begin
                    if (i < n)
                    begin
                        pq_node[i] = 8'(i);
                        pq_dist[i] = DIST_TOP;
                        pq_slot[i] = 9'(i);
                    end
                    else
                        pq_slot[i] = 9'(imh_pkg::MAX_NODES);
                end
                pq_count = 9'(n);
            end
            imh_pkg::FUNC_EXTRACT:
            begin
                if (pq_count == 0)
                begin
                    res.out_distance = DIST_TOP;
                    res.heap_was_empty = 1'b1;
                end
                else
                begin
                    res.out_node = pq_node[0];
                    res.out_distance = pq_dist[0];
                    if (pq_count != 1)
                        swap_slots(0, int'(pq_count) - 1);
                    pq_count = pq_count - 9'd1;
                    s = 0;
                    forever
                    begin
                        best = s;
                        l = 2 * s + 1;
                        r = 2 * s + 2;
                        if (l < pq_count && pq_dist[l] < pq_dist[best])
                            best = l;
                        if (r < pq_count && pq_dist[r] < pq_dist[best])
                            best = r;
                        if (best == s)
                            break;
                        swap_slots(best, s);
                        s = best;
                    end
                end
            end
            imh_pkg::FUNC_DECKEY:
            begin
                s = int'(pq_slot[op.node_id]);
                if (s < pq_count && op.req_dist < pq_dist[s])
                begin
                    pq_dist[s] = op.req_dist;
                    res.key_updated = 1'b1;
                    while (s > 0)
                    begin
                        p = (s - 1) / 2;
                        if (!(pq_dist[s] < pq_dist[p]))
                            break;
                        swap_slots(s, p);
                        s = p;
                    end
                end
            end
            default:
                res.is_member = (pq_slot[op.node_id] < pq_count);
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // send one op beat; the prediction is queued on acceptance
    task automatic send_op(input imh_pkg::func_t f, input logic [7:0] node,
                           input logic [31:0] dist_in);
        imh_pkg::in_beat_t op;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        op.func = f;
        op.node_id = node;
        op.req_dist = dist_in;
        // before the first init the slot table is unwritten: keep off reads of it
        if (!pq_ready_init && (f == imh_pkg::FUNC_DECKEY || f == imh_pkg::FUNC_MEMBER))
            op.func = imh_pkg::FUNC_EXTRACT;
        in_ch.valid = 1'b1;
        in_ch.data  = op;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (op.func == imh_pkg::FUNC_INIT)
            pq_ready_init = 1'b1;
        pending_results.push_back(heap_apply(op));
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [8:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        pq_limit = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // receiver: random stalls, optional long hold-off, field checks
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        imh_pkg::out_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", 32'(out_ch.data.out_node), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.data.out_node !== want.out_node)
                    report_mismatch("out_node", 32'(out_ch.data.out_node),
                                    32'(want.out_node));
                if (out_ch.data.out_distance !== want.out_distance)
                    report_mismatch("out_distance", out_ch.data.out_distance,
                                    want.out_distance);
                if (out_ch.data.heap_was_empty !== want.heap_was_empty)
                    report_mismatch("heap_was_empty", 32'(out_ch.data.heap_was_empty),
                                    32'(want.heap_was_empty));
                if (out_ch.data.is_member !== want.is_member)
                    report_mismatch("is_member", 32'(out_ch.data.is_member),
                                    32'(want.is_member));
                if (out_ch.data.key_updated !== want.key_updated)
                    report_mismatch("key_updated", 32'(out_ch.data.key_updated),
                                    32'(want.key_updated));
            end
        end
    end

    // extremes, empty heap, every op, ties, removed node, equal key
    task automatic test_directed();
        send_op(imh_pkg::FUNC_EXTRACT, 8'd0, 32'd0);
        write_node_count(9'd1);
        send_op(imh_pkg::FUNC_INIT, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_MEMBER, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_MEMBER, 8'd255, 32'd0);
        send_op(imh_pkg::FUNC_DECKEY, 8'd0, DIST_TOP);
        send_op(imh_pkg::FUNC_DECKEY, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_EXTRACT, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_EXTRACT, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_DECKEY, 8'd0, 32'd0);
        write_node_count(9'd0);
        send_op(imh_pkg::FUNC_INIT, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_EXTRACT, 8'd0, 32'd0);
        write_node_count(9'd511);
        send_op(imh_pkg::FUNC_INIT, 8'hFF, 32'd5);
        send_op(imh_pkg::FUNC_DECKEY, 8'd255, 32'd7);
        send_op(imh_pkg::FUNC_DECKEY, 8'd128, 32'd7);
        send_op(imh_pkg::FUNC_DECKEY, 8'd64, 32'd7);
        send_op(imh_pkg::FUNC_DECKEY, 8'd1, 32'hAAAA_5555);
        send_op(imh_pkg::FUNC_DECKEY, 8'd2, 32'h5555_AAAA);
        send_op(imh_pkg::FUNC_EXTRACT, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_EXTRACT, 8'd0, 32'd0);
        send_op(imh_pkg::FUNC_MEMBER, 8'd255, 32'd0);
        send_op(imh_pkg::FUNC_MEMBER, 8'd64, 32'd0);
    endtask

    // Dijkstra-like traffic: init, many decreases and extracts, some noise
    task automatic test_random(input int items, input logic [8:0] count);
        int k;
        logic [31:0] d;
        write_node_count(count);
        send_op(imh_pkg::FUNC_INIT, 8'($urandom), $urandom);
        for (k = 0; k < items; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                    send_op(imh_pkg::FUNC_EXTRACT, 8'($urandom), $urandom);
                3, 4, 5, 6:
                begin
                    d = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
                    send_op(imh_pkg::FUNC_DECKEY,
                            8'($urandom_range(count > 0 ? count : 1)), d);
                end
                7, 8:
                    send_op(imh_pkg::FUNC_MEMBER, 8'($urandom), $urandom);
                default:
                    send_op(imh_pkg::FUNC_DECKEY, 8'($urandom), $urandom);
            endcase
            if ($urandom_range(199) == 0)
                send_op(imh_pkg::FUNC_INIT, 8'($urandom), $urandom);
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_off_cycles = 600;
        repeat (12) send_op(imh_pkg::FUNC_MEMBER, 8'($urandom), $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        pq_limit = 9'd256;
        pq_count = '0;
        pq_ready_init = 1'b0;
        for (int i = 0; i < imh_pkg::MAX_NODES; i++)
            pq_slot[i] = 9'(imh_pkg::MAX_NODES);
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300, 9'd256);
        send_idle_pct = 57;
        test_random(300, 9'd20);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        test_random(300, 9'd7);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random(300, 9'd2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();

        drain();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
